>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the offset index design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define RLOI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RLOI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/rloi_pkg.sv
// ----------------------------------------------------------------------------
// rloi_pkg
// Shared types and constants of the regression line offset index.
// ----------------------------------------------------------------------------
`default_nettype none

package rloi_pkg;

  localparam int MAX_ENTRIES_DEF   = 1024;
  localparam int RESIDUAL_BITS_DEF = 32;

  localparam int POS_W     = 10;
  localparam int CNT_W     = 11;
  localparam int RES_IN_W  = 32;
  localparam int OFF_W     = 64;
  localparam int IDOFF_W   = 63;
  localparam int CFG_IDX_W = 3;
  localparam int QUO_W     = POS_W;      // line fraction quotient stays below 2^POS_W
  localparam int RP_W      = CNT_W + POS_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRY_COUNT = 3'd0,
    REG_SLOPE       = 3'd1,
    REG_INTERCEPT   = 3'd2,
    REG_ID_OFFSET   = 3'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } opcode_t;

  // Control bits that travel down the lookup pipeline with each transaction.
  typedef struct packed {
    logic valid;
    logic lookup;
    logic oor;
    logic single;
    logic in_store;
  } ctl_t;

endpackage

`default_nettype wire

>>> design/rloi_store.sv
// ----------------------------------------------------------------------------
// rloi_store
// Single-port residual memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rloi_store #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata_r <= mem[addr];
    end
  end

endmodule

`default_nettype wire

>>> design/rloi_cfg_div.sv
// ----------------------------------------------------------------------------
// rloi_cfg_div
// Bit-serial divider that splits the slope into quotient and remainder
// by entry_count minus one after a configuration change.
// ----------------------------------------------------------------------------
`default_nettype none

module rloi_cfg_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       go,
  input  wire logic [rloi_pkg::OFF_W-1:0] slope,
  input  wire logic [rloi_pkg::CNT_W-1:0] divisor,
  output logic                            running_r,
  output logic      [rloi_pkg::OFF_W-1:0] quo_r,
  output logic      [rloi_pkg::CNT_W-1:0] rem_r
);
  import rloi_pkg::*;

  localparam int STEP_W = $clog2(OFF_W);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              running_nxt;
  logic [OFF_W-1:0]  quo_nxt;
  logic [CNT_W-1:0]  rem_nxt;
  logic [CNT_W:0]    trial;

  always_comb begin
    running_nxt = running_r;
    step_nxt    = step_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    trial       = {rem_r, quo_r[OFF_W-1]};
    if (go) begin
      running_nxt = 1'b1;
      step_nxt    = '0;
      quo_nxt     = slope;
      rem_nxt     = '0;
    end else if (running_r) begin
      // Restoring step: the dividend bit shifts out as the quotient bit shifts in.
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = CNT_W'(trial - {1'b0, divisor});
        quo_nxt = {quo_r[OFF_W-2:0], 1'b1};
      end else begin
        rem_nxt = CNT_W'(trial);
        quo_nxt = {quo_r[OFF_W-2:0], 1'b0};
      end
      step_nxt = STEP_W'(step_r + 1'b1);
      if (step_r == STEP_W'(OFF_W - 1)) begin
        running_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      step_r    <= '0;
      quo_r     <= '0;
      rem_r     <= '0;
    end else begin
      running_r <= running_nxt;
      step_r    <= step_nxt;
      quo_r     <= quo_nxt;
      rem_r     <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/rloi_datapath.sv
// ----------------------------------------------------------------------------
// rloi_datapath
// Four-stage lookup pipeline: line products, residual and bias sum,
// fractional quotient in two halves, result select.
// ----------------------------------------------------------------------------
`default_nettype none

module rloi_datapath #(
  parameter int RESIDUAL_BITS = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire rloi_pkg::ctl_t             ctl_in,
  input  wire logic [rloi_pkg::POS_W-1:0] pos_in,
  input  wire logic [RESIDUAL_BITS-1:0]   stored_s1,
  input  wire logic [rloi_pkg::OFF_W-1:0] quo,
  input  wire logic [rloi_pkg::CNT_W-1:0] rem,
  input  wire logic [rloi_pkg::CNT_W-1:0] divisor,
  input  wire logic [rloi_pkg::OFF_W-1:0] bias,
  input  wire logic [rloi_pkg::OFF_W-1:0] intercept,
  output logic                            out_valid_r,
  output logic      [rloi_pkg::OFF_W-1:0] out_offset_r,
  output logic                            out_oor_r
);
  import rloi_pkg::*;

  localparam int HALF = QUO_W / 2;

  ctl_t              s1_ctl_r, s2_ctl_r, s3_ctl_r;
  logic [POS_W-1:0]  s1_pos_r;
  logic [OFF_W-1:0]  s2_qp_r, s2_res_r, s3_sum_r;
  logic [RP_W-1:0]   s2_rp_r, s3_rp_r, rp_mid, rp_low;
  logic [QUO_W-1:0]  s3_qhi_r, qhi, qlo;
  logic [OFF_W-1:0]  stored64, offset_nxt;

  assign stored64 = s1_ctl_r.in_store ? OFF_W'(stored_s1) : '0;

  // Upper quotient bits of rem*pos/divisor; the quotient is below 2^QUO_W.
  always_comb begin
    rp_mid = s2_rp_r;
    qhi    = '0;
    for (int i = QUO_W - 1; i >= HALF; i--) begin
      if (rp_mid >= (RP_W'(divisor) << i)) begin
        rp_mid = rp_mid - (RP_W'(divisor) << i);
        qhi[i] = 1'b1;
      end
    end
  end

  always_comb begin
    rp_low = s3_rp_r;
    qlo    = s3_qhi_r;
    for (int i = HALF - 1; i >= 0; i--) begin
      if (rp_low >= (RP_W'(divisor) << i)) begin
        rp_low = rp_low - (RP_W'(divisor) << i);
        qlo[i] = 1'b1;
      end
    end
  end

  always_comb begin
    offset_nxt = '0;
    if (s3_ctl_r.lookup && !s3_ctl_r.oor) begin
      offset_nxt = s3_ctl_r.single ? intercept : s3_sum_r + OFF_W'(qlo);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r    <= '0;
      s2_ctl_r    <= '0;
      s3_ctl_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_ctl_r    <= ctl_in;
      s2_ctl_r    <= s1_ctl_r;
      s3_ctl_r    <= s2_ctl_r;
      out_valid_r <= s3_ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_pos_r     <= pos_in;
    s2_qp_r      <= quo * OFF_W'(s1_pos_r);
    s2_rp_r      <= RP_W'(rem) * RP_W'(s1_pos_r);
    s2_res_r     <= stored64;
    s3_sum_r     <= s2_qp_r + s2_res_r + bias;
    s3_rp_r      <= rp_mid;
    s3_qhi_r     <= qhi;
    out_offset_r <= offset_nxt;
    out_oor_r    <= s3_ctl_r.lookup && s3_ctl_r.oor;
  end

endmodule

`default_nettype wire

>>> design/regression_line_offset_index.sv
// ----------------------------------------------------------------------------
// regression_line_offset_index
// Offset index rebuilt from a regression line plus stored residuals.
// ----------------------------------------------------------------------------
//  Channel   Ports                                   Handshake
//  input     in_opcode, in_position, in_residual     start high, busy low
//  result    out_offset, out_out_of_range            out_valid, one cycle
//  config    cfg_index, cfg_data                     cfg_we
//
// One transaction enters per clock while busy is low; its result is registered
// in s1, s2, s3 and the output register. A write of entry_count or the slope
// keeps busy high through the launch and all steps of the serial slope divider.
// Configuration writes are still taken while busy is high.
// Reset is synchronous; busy is high while rst_n is low.
// The receiver cannot stall, so nothing is held back on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module regression_line_offset_index #(
  parameter int MAX_ENTRIES   = rloi_pkg::MAX_ENTRIES_DEF,
  parameter int RESIDUAL_BITS = rloi_pkg::RESIDUAL_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_opcode,
  input  wire logic [rloi_pkg::POS_W-1:0]     in_position,
  input  wire logic [rloi_pkg::RES_IN_W-1:0]  in_residual,
  output logic                                out_valid,
  output logic      [rloi_pkg::OFF_W-1:0]     out_offset,
  output logic                                out_out_of_range,
  input  wire logic                           cfg_we,
  input  wire logic [rloi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rloi_pkg::OFF_W-1:0]     cfg_data
);
  import rloi_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);

  logic [CNT_W-1:0]   entry_count_r;
  logic [OFF_W-1:0]   slope_r, intercept_r;
  logic [IDOFF_W-1:0] id_offset_r;
  logic               div_go_r, div_go_nxt;
  logic               div_running;
  logic [OFF_W-1:0]   quo;
  logic [CNT_W-1:0]   rem;
  logic [CNT_W-1:0]   divisor;
  logic [OFF_W-1:0]   bias;
  logic               accept;
  ctl_t               ctl0;
  logic [RESIDUAL_BITS-1:0] rd_data;
  logic               store_we;

  assign busy    = !rst_n || div_go_r || div_running;
  assign accept  = start && !busy;
  assign divisor = CNT_W'(entry_count_r - 1'b1);
  assign bias    = intercept_r - {1'b0, id_offset_r};

  always_comb begin
    div_go_nxt = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index) inside
        REG_ENTRY_COUNT, REG_SLOPE: div_go_nxt = 1'b1;
        default:                    div_go_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      slope_r       <= '0;
      intercept_r   <= '0;
      id_offset_r   <= '0;
      div_go_r      <= 1'b0;
    end else begin
      div_go_r <= div_go_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENTRY_COUNT: entry_count_r <= cfg_data[CNT_W-1:0];
          REG_SLOPE:       slope_r       <= cfg_data;
          REG_INTERCEPT:   intercept_r   <= cfg_data;
          REG_ID_OFFSET:   id_offset_r   <= cfg_data[IDOFF_W-1:0];
          default:         ;
        endcase
      end
    end
  end

  always_comb begin
    ctl0.valid    = accept;
    ctl0.lookup   = (in_opcode == OP_LOOKUP);
    ctl0.oor      = ({1'b0, in_position} >= entry_count_r);
    ctl0.single   = (entry_count_r == CNT_W'(1));
    ctl0.in_store = (int'(in_position) < MAX_ENTRIES);
  end

  assign store_we = accept && (in_opcode == OP_WRITE) && ctl0.in_store;

  rloi_store #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (RESIDUAL_BITS)
  ) u_store (
    .clk     (clk),
    .we      (store_we),
    .addr    (AW'(in_position)),
    .wdata   (RESIDUAL_BITS'(in_residual)),
    .rdata_r (rd_data)
  );

  rloi_cfg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go_r),
    .slope     (slope_r),
    .divisor   (divisor),
    .running_r (div_running),
    .quo_r     (quo),
    .rem_r     (rem)
  );

  rloi_datapath #(
    .RESIDUAL_BITS (RESIDUAL_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl_in       (ctl0),
    .pos_in       (in_position),
    .stored_s1    (rd_data),
    .quo          (quo),
    .rem          (rem),
    .divisor      (divisor),
    .bias         (bias),
    .intercept    (intercept_r),
    .out_valid_r  (out_valid),
    .out_offset_r (out_offset),
    .out_oor_r    (out_out_of_range)
  );

  `RLOI_ASSERT(a_latency, clk, rst_n, accept |-> ##4 out_valid, "result missing")
  `RLOI_ASSERT(a_no_extra, clk, rst_n, out_valid |-> $past(accept, 4), "stray result")
  `RLOI_ASSERT_ALWAYS(a_oor_zero, clk, (out_valid && out_out_of_range) |-> (out_offset == '0), "oor offset")
  `RLOI_ASSERT(a_div_cause, clk, rst_n, $rose(div_running) |-> $past(div_go_r), "stray divide")

endmodule

`default_nettype wire
